// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers shared by the base64 encoder rtl, empty for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property that must hold at every edge out of reset
`define B64_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// same-cycle implication
`define B64_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`else
`define B64_ASSERT(label, clk, rst, prop, msg)
`define B64_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`endif

`endif

// File: sv/b64e_pkg.sv
// ----------------------------------------------------------------------------
// b64e_pkg
// types, constants and the alphabet function of the base64 stream encoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package b64e_pkg;

   // characters per line before a wrap newline
   localparam int LINE_LIMIT  = 76;
   localparam int COL_W       = $clog2(LINE_LIMIT + 1);

   localparam logic [7:0] NEWLINE_CHAR = 8'd10;
   localparam logic [7:0] PAD_CHAR     = 8'd61;

   // group job queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // characters per job and slot counter width
   localparam int JOB_CHARS   = 4;
   localparam int SLOT_W      = $clog2(JOB_CHARS + 1);

   // configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_NO_LINE_BREAKS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NO_PADDING     = 2'd1;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       out_last;
   } rsp_type;

   // one group of characters handed from front to back
   typedef struct packed {
      logic [JOB_CHARS-1:0][7:0] chars;
      logic [SLOT_W-1:0]         cnt;
      logic                      last;
   } job_type;

   // standard base64 alphabet
   function automatic logic [7:0] b64_char(input logic [5:0] v);
      logic [7:0] w;
      w = {2'b00, v};
      if (v < 6'd26)      b64_char = 8'd65 + w;
      else if (v < 6'd52) b64_char = 8'd71 + w;   // 'a' - 26
      else if (v < 6'd62) b64_char = w - 8'd4;    // '0' - 52
      else if (v == 6'd62) b64_char = 8'd43;      // '+'
      else                b64_char = 8'd47;       // '/'
   endfunction

endpackage

// File: sv/b64e_front.sv
// ----------------------------------------------------------------------------
// b64e_front
// collects bytes in threes and turns each group or tail into a character job
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module b64e_front
   import b64e_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    no_padding,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    job_valid,
   input  logic    job_ready,
   output job_type job_data
);

   logic [15:0] held_bytes_ff, held_bytes_in;
   logic [1:0]  held_cnt_ff, held_cnt_in;
   logic        accept;
   logic [23:0] grp;

   assign req_ready = job_ready;
   assign accept    = req_valid && job_ready;

   always_comb begin
      held_bytes_in  = held_bytes_ff;
      held_cnt_in    = held_cnt_ff;
      grp            = '0;
      job_data.chars = '0;
      job_data.cnt   = '0;
      job_data.last  = req_data.in_last;
      job_valid      = 1'b0;
      case (held_cnt_ff)
         2'd2: begin
            grp            = {held_bytes_ff, req_data.in_byte};
            job_data.chars = {b64_char(grp[5:0]), b64_char(grp[11:6]),
                              b64_char(grp[17:12]), b64_char(grp[23:18])};
            job_data.cnt   = SLOT_W'(JOB_CHARS);
            job_valid      = accept;
            held_bytes_in  = '0;
            held_cnt_in    = 2'd0;
         end
         2'd1: begin
            grp = {held_bytes_ff[15:8], req_data.in_byte, 8'h00};
            if (req_data.in_last) begin
               job_data.chars = {PAD_CHAR, b64_char(grp[11:6]),
                                 b64_char(grp[17:12]), b64_char(grp[23:18])};
               job_data.cnt   = no_padding ? SLOT_W'(3) : SLOT_W'(4);
               job_valid      = accept;
               held_bytes_in  = '0;
               held_cnt_in    = 2'd0;
            end else begin
               held_bytes_in = {held_bytes_ff[15:8], req_data.in_byte};
               held_cnt_in   = 2'd2;
            end
         end
         default: begin
            // empty, and the unreachable count of three
            grp = {req_data.in_byte, 16'h0000};
            if (req_data.in_last) begin
               job_data.chars = {PAD_CHAR, PAD_CHAR,
                                 b64_char(grp[17:12]), b64_char(grp[23:18])};
               job_data.cnt   = no_padding ? SLOT_W'(2) : SLOT_W'(4);
               job_valid      = accept;
               held_bytes_in  = '0;
               held_cnt_in    = 2'd0;
            end else begin
               held_bytes_in = {req_data.in_byte, 8'h00};
               held_cnt_in   = 2'd1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_bytes_ff <= '0;
         held_cnt_ff   <= 2'd0;
      end else if (accept) begin
         held_bytes_ff <= held_bytes_in;
         held_cnt_ff   <= held_cnt_in;
      end
   end

endmodule

// File: sv/b64e_queue.sv
// ----------------------------------------------------------------------------
// b64e_queue
// short register queue of character jobs between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module b64e_queue
   import b64e_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  job_type push_data,
   output logic    pop_valid,
   input  logic    pop_ready,
   output job_type pop_data
);

   job_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff;
   logic                do_push, do_pop;

   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
      next_ptr = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= next_ptr(wr_ptr_ff);
         if (do_pop)  rd_ptr_ff <= next_ptr(rd_ptr_ff);
         if (do_push && !do_pop)      count_ff <= count_ff + 1'b1;
         else if (do_pop && !do_push) count_ff <= count_ff - 1'b1;
      end
   end

endmodule

// File: sv/b64e_back.sv
// ----------------------------------------------------------------------------
// b64e_back
// sends the characters of each job one a cycle while the output is not stalled, with line wrapping and a final newline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module b64e_back
   import b64e_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             no_line_breaks,
   input  logic             job_valid,
   output logic             job_ready,
   input  job_type          job_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   output logic [COL_W-1:0] line_col
);

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic              advance;

   assign advance  = job_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign line_col  = col_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      idx_in       = idx_ff;
      col_in       = col_ff;
      job_ready    = 1'b0;
      if (advance) begin
         rsp_valid_in = 1'b1;
         if (idx_ff < job_data.cnt) begin
            if (!no_line_breaks && (col_ff >= COL_W'(LINE_LIMIT))) begin
               // wrap newline, the character follows next
               rsp_data_in = '{out_char: NEWLINE_CHAR, out_last: 1'b0};
               col_in      = '0;
            end else begin
               rsp_data_in = '{out_char: job_data.chars[idx_ff[1:0]], out_last: 1'b0};
               if (!no_line_breaks) col_in = col_ff + 1'b1;
               if (!job_data.last && (idx_ff == job_data.cnt - 1'b1)) begin
                  job_ready = 1'b1;
                  idx_in    = '0;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end else begin
            // terminating newline
            rsp_data_in = '{out_char: NEWLINE_CHAR, out_last: 1'b1};
            col_in      = '0;
            job_ready   = 1'b1;
            idx_in      = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         col_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
         col_ff       <= col_in;
      end
   end

endmodule

// File: sv/base64_stream_encoder_core.sv
// ----------------------------------------------------------------------------
// base64_stream_encoder_core
// streaming base64 encoder with optional padding and line wrapping
// ----------------------------------------------------------------------------
// channel  dir  handshake            payload
// req      in   req_valid/req_ready  req_data  (in_byte, in_last)
// rsp      out  rsp_valid/rsp_ready  rsp_data  (out_char, out_last)
// csr      in   csr_valid/csr_ready  csr_index, csr_wdata
//
// a request is taken while the queue has room; the back end sends one character
// a cycle unless rsp stalls, so a full group of three requests makes four
// characters, plus a wrap newline now and then and the final newline of a message;
// sustained throughput is set by the back end character loop
// the front stalls only once two jobs wait in the queue; csr_ready is always high
// reset is synchronous; it empties the queue, clears the held group, the line
// column and returns config to padding and wrapping on
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module base64_stream_encoder_core
   import b64e_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic                 csr_wdata
);

   // configuration registers
   logic no_line_breaks_ff;
   logic no_padding_ff;

   // front to queue
   logic    fq_valid, fq_ready;
   job_type fq_data;

   // queue to back
   logic    qb_valid, qb_ready;
   job_type qb_data;

   logic [COL_W-1:0] line_col;

   assign csr_ready = 1'b1;

   // register writes, unknown indexes ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         no_line_breaks_ff <= 1'b0;
         no_padding_ff     <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_NO_LINE_BREAKS: no_line_breaks_ff <= csr_wdata;
            CSR_NO_PADDING:     no_padding_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // front: grouping of bytes, alphabet lookup, padding
   b64e_front u_front (
      .clock      (clock),
      .reset      (reset),
      .no_padding (no_padding_ff),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .job_valid  (fq_valid),
      .job_ready  (fq_ready),
      .job_data   (fq_data)
   );

   // two-entry job queue lets front and back stall apart
   b64e_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_data  (fq_data),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_data   (qb_data)
   );

   // back: one character a cycle into the output register while rsp is not stalled, wrap newlines
   b64e_back u_back (
      .clock          (clock),
      .reset          (reset),
      .no_line_breaks (no_line_breaks_ff),
      .job_valid      (qb_valid),
      .job_ready      (qb_ready),
      .job_data       (qb_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .line_col       (line_col)
   );

   // the final mark only ever rides on a newline
   `B64_ASSERT_IMPL(a_last_is_newline, clock, reset, rsp_valid && rsp_data.out_last,
      rsp_data.out_char == NEWLINE_CHAR, "last mark on a non-newline character")
   // any newline on show has just restarted the line
   `B64_ASSERT_IMPL(a_newline_col_zero, clock, reset,
      rsp_valid && (rsp_data.out_char == NEWLINE_CHAR), line_col == '0,
      "newline sent without a column restart")
   // the column never passes the line limit
   `B64_ASSERT(a_col_in_range, clock, reset, line_col <= COL_W'(LINE_LIMIT),
      "line column beyond the limit")

endmodule

// File: verif/base64_stream_encoder_checker.sv
// ----------------------------------------------------------------------------
// base64_stream_encoder_checker
// watches the req, rsp and csr channels of the encoder, predicts the output
// characters of every accepted request and compares them in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module base64_stream_encoder_checker
   import b64e_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  req_type              req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  rsp_type              rsp_data,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic                 csr_wdata,
   output int                   error_count,
   output int                   chars_pending
);

   localparam logic [8*64-1:0] ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   logic        wrap_off;
   logic        pad_off;
   logic [15:0] group_bytes;
   logic [1:0]  group_fill;
   logic [10:0] column;
   rsp_type     expected_chars[$];
   int          fails = 0;
   int          waiting = 0;

   assign error_count   = fails;
   assign chars_pending = waiting;

   function automatic logic [7:0] sextet_char(input logic [5:0] v);
      return ALPHABET[511 - 8 * int'(v) -: 8];
   endfunction

   task automatic push_raw(input logic [7:0] ch, input logic is_end);
      rsp_type r;
      r.out_char = ch;
      r.out_last = is_end;
      expected_chars.push_back(r);
   endtask

   // a text character, with a wrap newline ahead of it once the line is full
   task automatic push_text(input logic [7:0] ch);
      if (!wrap_off) begin
         if (column >= LINE_LIMIT) begin
            push_raw(NEWLINE_CHAR, 1'b0);
            column = '0;
         end
         column = column + 11'd1;
      end
      push_raw(ch, 1'b0);
   endtask

   task automatic encode_byte(input req_type rq);
      logic [23:0] grp;
      if (group_fill == 2'd2) begin
         grp = {group_bytes, rq.in_byte};
         for (int k = 0; k < 4; k++)
            push_text(sextet_char(grp[23 - 6 * k -: 6]));
         group_bytes = '0;
         group_fill  = 2'd0;
      end else if (group_fill == 2'd1) begin
         group_bytes[7:0] = rq.in_byte;
         group_fill       = 2'd2;
      end else begin
         group_bytes = {rq.in_byte, 8'h00};
         group_fill  = 2'd1;
      end
      if (rq.in_last) begin
         grp = {group_bytes, 8'h00};
         if (group_fill == 2'd2) begin
            for (int k = 0; k < 3; k++)
               push_text(sextet_char(grp[23 - 6 * k -: 6]));
            if (!pad_off)
               push_text(PAD_CHAR);
         end else if (group_fill == 2'd1) begin
            for (int k = 0; k < 2; k++)
               push_text(sextet_char(grp[23 - 6 * k -: 6]));
            if (!pad_off) begin
               push_text(PAD_CHAR);
               push_text(PAD_CHAR);
            end
         end
         push_raw(NEWLINE_CHAR, 1'b1);
         group_bytes = '0;
         group_fill  = 2'd0;
         column      = '0;
      end
   endtask

   always @(posedge clock) begin
      rsp_type oldest;
      if (reset) begin
         wrap_off    = 1'b0;
         pad_off     = 1'b0;
         group_bytes = '0;
         group_fill  = 2'd0;
         column      = '0;
         expected_chars.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_NO_LINE_BREAKS: wrap_off = csr_wdata;
               CSR_NO_PADDING:     pad_off  = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            encode_byte(req_data);
         if (rsp_valid && rsp_ready) begin
            if (expected_chars.size() == 0) begin
               $error("unexpected response: out_char %0d out_last %0d",
                      rsp_data.out_char, rsp_data.out_last);
               fails++;
            end else begin
               oldest = expected_chars.pop_front();
               if (rsp_data.out_char !== oldest.out_char) begin
                  $error("out_char expected %0d actual %0d",
                         oldest.out_char, rsp_data.out_char);
                  fails++;
               end
               if (rsp_data.out_last !== oldest.out_last) begin
                  $error("out_last expected %0d actual %0d",
                         oldest.out_last, rsp_data.out_last);
                  fails++;
               end
            end
         end
      end
      waiting = expected_chars.size();
   end

endmodule

// File: verif/base64_stream_encoder_core_test.sv
// ----------------------------------------------------------------------------
// base64_stream_encoder_core_test
// drives short directed messages and then random messages through the
// encoder under both padding and wrapping settings, with random idling on
// both channels; the checker beside the block predicts every character
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module base64_stream_encoder_core_test;
   import b64e_pkg::*;

   // cycles without any accepted transfer before the run is abandoned
   localparam int WATCHDOG_LIMIT = 5000;
   // random request bytes to send after the directed messages
   localparam int RANDOM_BYTES   = 300;
   // quiet cycles after the last expected character, before a csr write
   localparam int SETTLE_CYCLES  = 16;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_NO_LINE_BREAKS;
   logic                 csr_wdata = 1'b0;

   int   error_count;
   int   chars_pending;
   int   idle_cycles = 0;
   // random idling on both channels; cleared for a stretch mid-run
   logic gaps_on = 1'b1;

   base64_stream_encoder_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   base64_stream_encoder_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .error_count   (error_count),
      .chars_pending (chars_pending)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver back-pressure, changed on the falling edge only
   always @(negedge clock) begin
      rsp_ready = !gaps_on || ($urandom_range(0, 99) >= 20);
   end

   // watchdog: any accepted transfer restarts the count
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[base64_stream_encoder_core] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // one request byte; entered and left on a falling edge
   task automatic send_byte(input logic [7:0] b, input logic is_end);
      // random gap before the request; valid stays high if there is none
      while (gaps_on && $urandom_range(0, 99) < 20) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_data  = '{in_byte: b, in_last: is_end};
      req_valid = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // a whole message of random bytes
   task automatic send_message(input int len);
      for (int i = 0; i < len; i++)
         send_byte(8'($urandom_range(0, 255)), i == len - 1);
   endtask

   // drop valid and let every predicted character drain, then a quiet spell
   task automatic settle();
      req_valid = 1'b0;
      while (chars_pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic val);
      csr_index = idx;
      csr_wdata = val;
      csr_valid = 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   initial begin
      int sent;
      int msg_len;
      int phase_left;
      int pick;

      // synchronous reset held from the start, released on a falling edge
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // padding and wrapping on
      write_csr(CSR_NO_LINE_BREAKS, 1'b0);
      write_csr(CSR_NO_PADDING, 1'b0);

      // one byte, all zeros and all ones: two characters and two pads
      send_byte(8'h00, 1'b1);
      send_byte(8'hff, 1'b1);
      // two bytes: three characters and one pad
      send_byte(8'hff, 1'b0);
      send_byte(8'hff, 1'b1);
      // full group on the last byte, no padding needed
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b1);
      // full group of '+' characters
      send_byte(8'hfb, 1'b0);
      send_byte(8'hef, 1'b0);
      send_byte(8'hbe, 1'b1);
      // a group of '/' then a lone byte with the top bit set
      send_byte(8'hff, 1'b0);
      send_byte(8'hff, 1'b0);
      send_byte(8'hff, 1'b0);
      send_byte(8'h80, 1'b1);
      settle();

      // padding and wrapping off
      write_csr(CSR_NO_LINE_BREAKS, 1'b1);
      write_csr(CSR_NO_PADDING, 1'b1);
      send_byte(8'h00, 1'b1);
      send_byte(8'h12, 1'b0);
      send_byte(8'h34, 1'b1);
      send_byte(8'hff, 1'b0);
      send_byte(8'h5a, 1'b0);
      send_byte(8'ha5, 1'b1);
      settle();
      write_csr(CSR_NO_LINE_BREAKS, 1'b0);
      write_csr(CSR_NO_PADDING, 1'b0);

      // random messages; config changes at random points, some mid-message,
      // where the line column must carry across the change
      sent       = 0;
      phase_left = $urandom_range(30, 90);
      while (sent < RANDOM_BYTES) begin
         pick = $urandom_range(0, 9);
         if (pick < 5)
            msg_len = $urandom_range(1, 6);
         else if (pick < 8)
            msg_len = $urandom_range(54, 59);   // lines near the limit
         else
            msg_len = $urandom_range(7, 130);
         for (int i = 0; i < msg_len; i++) begin
            send_byte(8'($urandom_range(0, 255)), i == msg_len - 1);
            sent++;
            phase_left--;
            if (phase_left == 0) begin
               settle();
               write_csr(CSR_NO_LINE_BREAKS, 1'($urandom_range(0, 1)));
               write_csr(CSR_NO_PADDING, 1'($urandom_range(0, 1)));
               phase_left = $urandom_range(30, 90);
            end
            // a long stretch without idling on either side
            gaps_on = !(sent >= 120 && sent < 200);
         end
      end

      // a last message at full defaults, then drain
      settle();
      write_csr(CSR_NO_LINE_BREAKS, 1'b0);
      write_csr(CSR_NO_PADDING, 1'b0);
      send_message(3);
      settle();

      if (error_count == 0 && chars_pending == 0) begin
         $display("[base64_stream_encoder_core] OK");
      end else begin
         $display("[base64_stream_encoder_core] ERROR");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+sv
sv/b64e_pkg.sv
sv/b64e_front.sv
sv/b64e_queue.sv
sv/b64e_back.sv
sv/base64_stream_encoder_core.sv
verif/base64_stream_encoder_checker.sv
verif/base64_stream_encoder_core_test.sv
